>>> hdl/dual_cpu_memory_map_decoder_top_defines.svh
// Assertion macros for the memory map decoder checker.
// Included by the checker; needs clk and rst_n in the including scope.
`ifndef DUAL_CPU_MEMORY_MAP_DECODER_TOP_DEFINES_SVH
`define DUAL_CPU_MEMORY_MAP_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define DCMD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memory map decoder check failed");

// Next-cycle implication, idle during reset.
`define DCMD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memory map decoder check failed");

`endif

>>> hdl/dcmd_pkg.sv
// Package for the dual-CPU memory map decoder: item types, region codes,
// register indexes, map constants and the fit test. No dependencies.
`timescale 1ns / 1ps

package dcmd_pkg;

  localparam int unsigned ITCM_BYTES = 32768;
  localparam int unsigned DTCM_BYTES = 16384;

  localparam logic [3:0] RG_ITCM  = 4'd0;
  localparam logic [3:0] RG_DTCM  = 4'd1;
  localparam logic [3:0] RG_MAIN  = 4'd2;
  localparam logic [3:0] RG_SWRAM = 4'd3;
  localparam logic [3:0] RG_WRAM7 = 4'd4;
  localparam logic [3:0] RG_BIOS9 = 4'd5;
  localparam logic [3:0] RG_BIOS7 = 4'd6;
  localparam logic [3:0] RG_IO    = 4'd7;
  localparam logic [3:0] RG_NONE  = 4'd8;

  localparam logic [2:0] CFG_ITCM_ON    = 3'd0;
  localparam logic [2:0] CFG_ITCM_SPAN  = 3'd1;
  localparam logic [2:0] CFG_DTCM_ON    = 3'd2;
  localparam logic [2:0] CFG_DTCM_START = 3'd3;
  localparam logic [2:0] CFG_DTCM_SPAN  = 3'd4;

  localparam logic [31:0] MAIN_BASE  = 32'h0200_0000;
  localparam logic [31:0] MAIN_MASK  = 32'h003F_FFFF;
  localparam logic [31:0] SWRAM_BASE = 32'h0300_0000;
  localparam logic [31:0] SWRAM_MASK = 32'h0000_7FFF;
  localparam logic [31:0] WRAM7_BASE = 32'h0380_0000;
  localparam logic [31:0] WRAM7_MASK = 32'h0000_FFFF;
  localparam logic [31:0] BIOS9_BASE = 32'hFFFF_0000;
  localparam logic [31:0] BIOS9_MASK = 32'h0000_0FFF;
  localparam logic [31:0] BIOS7_TOP  = 32'h0000_4000;
  localparam logic [31:0] BIOS7_MASK = 32'h0000_3FFF;
  localparam logic [31:0] IO_BASE    = 32'h0400_0000;
  localparam logic [31:0] IO_TOP     = 32'h0500_0000;

  localparam logic [31:0] ITCM_MASK  = 32'(ITCM_BYTES - 1);

  typedef struct packed {
    logic        cpu_sel;
    logic [31:0] address;
    logic [2:0]  width_bytes;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  region;
    logic [21:0] offset;
    logic        exec_ram;
  } out_item_t;

  // True when the access [off, off+len) stays inside a store of size bytes.
  function automatic logic fits(logic [31:0] off, logic [2:0] len, logic [32:0] size);
    logic [32:0] sum;
    sum = {1'b0, off} + {30'd0, len};
    return sum <= size;
  endfunction

endpackage

>>> hdl/dual_cpu_memory_map_decoder_top.sv
// Top level of the dual-CPU memory map decoder: input register, decode, result register.
// Depends on dcmd_pkg.
`timescale 1ns / 1ps

//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+---------------------------
//  input   | in_valid in_ready in_data      | in        | in_item_t (cpu, addr, len)
//  result  | out_valid out_ready out_data   | out       | out_item_t (region, offs)
//  config  | cfg_valid cfg_ready cfg_index  | in        | cfg_data, 32 bits
//
// Each item passes through the input register and then moves to the result register, from which
// its result is offered; one item per cycle is sustained while out_ready stays high.
// Reset clears the valid flags and the TCM registers; no clearing pass.
// A stalled result holds the result register and lets the input register fill,
// after which in_ready drops. cfg_ready is always high.

module dual_cpu_memory_map_decoder_top
  import dcmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        itcm_on_r,    itcm_on_nxt;
  logic [31:0] itcm_span_r,  itcm_span_nxt;
  logic        dtcm_on_r,    dtcm_on_nxt;
  logic [31:0] dtcm_start_r, dtcm_start_nxt;
  logic [31:0] dtcm_span_r,  dtcm_span_nxt;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r,  s1_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r,  out_item_nxt;

  logic      s1_adv;
  out_item_t dec;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    itcm_on_nxt    = itcm_on_r;
    itcm_span_nxt  = itcm_span_r;
    dtcm_on_nxt    = dtcm_on_r;
    dtcm_start_nxt = dtcm_start_r;
    dtcm_span_nxt  = dtcm_span_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ITCM_ON:    itcm_on_nxt    = cfg_data[0];
        CFG_ITCM_SPAN:  itcm_span_nxt  = cfg_data;
        CFG_DTCM_ON:    dtcm_on_nxt    = cfg_data[0];
        CFG_DTCM_START: dtcm_start_nxt = cfg_data;
        CFG_DTCM_SPAN:  dtcm_span_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the registered item in one pass, highest priority rule first
  always_comb begin
    logic        first;
    logic [31:0] a;
    logic [2:0]  len;
    logic        itcm_span_hit;
    logic        dtcm_hit;
    logic [31:0] dtcm_off;
    logic [31:0] o;
    logic        hit;

    first         = !s1_item_r.cpu_sel;
    a             = s1_item_r.address;
    len           = s1_item_r.width_bytes;
    itcm_span_hit = first && itcm_on_r && (itcm_span_r != 32'd0) &&
                    (a < MAIN_BASE) && (a < itcm_span_r);
    dtcm_off      = a - dtcm_start_r;
    dtcm_hit      = first && dtcm_on_r && (dtcm_span_r != 32'd0) &&
                    (a >= dtcm_start_r) && (dtcm_off < dtcm_span_r);
    o             = 32'd0;
    hit           = 1'b0;
    dec.region    = RG_NONE;

    if (itcm_span_hit && fits(a & ITCM_MASK, len, 33'(ITCM_BYTES))) begin
      hit = 1'b1; dec.region = RG_ITCM; o = a & ITCM_MASK;
    end else if (dtcm_hit && fits(dtcm_off, len, 33'(DTCM_BYTES))) begin
      hit = 1'b1; dec.region = RG_DTCM; o = dtcm_off;
    end else if (a >= MAIN_BASE && a < SWRAM_BASE &&
                 fits(a & MAIN_MASK, len, {1'b0, MAIN_MASK} + 33'd1)) begin
      hit = 1'b1; dec.region = RG_MAIN; o = a & MAIN_MASK;
    end else if (a >= SWRAM_BASE && a < WRAM7_BASE &&
                 fits(a & SWRAM_MASK, len, {1'b0, SWRAM_MASK} + 33'd1)) begin
      hit = 1'b1; dec.region = RG_SWRAM; o = a & SWRAM_MASK;
    end else if (a >= WRAM7_BASE && a < IO_BASE &&
                 fits(a & WRAM7_MASK, len, {1'b0, WRAM7_MASK} + 33'd1)) begin
      hit = 1'b1; dec.region = RG_WRAM7; o = a & WRAM7_MASK;
    end else if (first && a >= BIOS9_BASE &&
                 fits(a & BIOS9_MASK, len, {1'b0, BIOS9_MASK} + 33'd1)) begin
      hit = 1'b1; dec.region = RG_BIOS9; o = a & BIOS9_MASK;
    end else if (!first && a < BIOS7_TOP &&
                 fits(a & BIOS7_MASK, len, {1'b0, BIOS7_MASK} + 33'd1)) begin
      hit = 1'b1; dec.region = RG_BIOS7; o = a & BIOS7_MASK;
    end

    if (!hit) begin
      o          = 32'd0;
      dec.region = (a >= IO_BASE && a < IO_TOP) ? RG_IO : RG_NONE;
    end
    dec.offset   = o[21:0];
    dec.exec_ram = itcm_span_hit || (a >= MAIN_BASE && a < IO_BASE);
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      s1_item_nxt  = in_data;
    end
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_item_nxt = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itcm_on_r    <= 1'b0;
      itcm_span_r  <= 32'd0;
      dtcm_on_r    <= 1'b0;
      dtcm_start_r <= 32'd0;
      dtcm_span_r  <= 32'd0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      itcm_on_r    <= itcm_on_nxt;
      itcm_span_r  <= itcm_span_nxt;
      dtcm_on_r    <= dtcm_on_nxt;
      dtcm_start_r <= dtcm_start_nxt;
      dtcm_span_r  <= dtcm_span_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

>>> hdl/dcmd_checker.sv
// Port-level checker for the memory map decoder, bound to the top level.
// Depends on dcmd_pkg and dual_cpu_memory_map_decoder_top_defines.svh.
`timescale 1ns / 1ps
`include "dual_cpu_memory_map_decoder_top_defines.svh"

module dcmd_checker
  import dcmd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  logic io_like;
  logic ram_like;

  assign io_like  = out_data.region == RG_IO || out_data.region == RG_NONE;
  assign ram_like = out_data.region == RG_MAIN || out_data.region == RG_SWRAM ||
                    out_data.region == RG_WRAM7;

  // Region code stays within the defined set
  `DCMD_ASSERT_IMP(a_region_range, out_valid, out_data.region <= RG_NONE)

  // I/O and unmapped items carry no offset
  `DCMD_ASSERT_IMP(a_io_offset_zero, out_valid && io_like, out_data.offset == 22'd0)

  // RAM regions always lie in the executable window
  `DCMD_ASSERT_IMP(a_ram_exec, out_valid && ram_like, out_data.exec_ram)

  // Hold a stalled result item
  `DCMD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An empty result stage never stalls the input
  `DCMD_ASSERT_IMP(a_in_free, in_valid && !out_valid, in_ready)

endmodule

bind dual_cpu_memory_map_decoder_top dcmd_checker u_dcmd_checker (.*);

>>> sim/tb.sv
// Testbench for dual_cpu_memory_map_decoder_top: drives accesses from both CPUs
// under several TCM settings and checks region, offset and exec flag per item.
// Depends on dcmd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import dcmd_pkg::*;

  localparam logic       CPU_MAIN       = 1'b0;
  localparam logic       CPU_SUB        = 1'b1;
  localparam logic [2:0] CFG_SPARE_LO   = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI   = 3'd7;
  localparam int         PHASES         = 7;
  localparam int         ITEMS_PER_PHASE = 86;
  localparam int         HOLD_CYCLES    = 80;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         QUIET_LIMIT    = 1000;

  typedef struct packed {
    logic [31:0] itcm_on;
    logic [31:0] itcm_span;
    logic [31:0] dtcm_on;
    logic [31:0] dtcm_start;
    logic [31:0] dtcm_span;
  } map_setting_t;

  // Expected decodes in acceptance order, plus a private copy of the TCM registers.
  class decode_scoreboard;
    logic        itcm_on;
    logic [31:0] itcm_span;
    logic        dtcm_on;
    logic [31:0] dtcm_start;
    logic [31:0] dtcm_span;
    out_item_t   pending[$];
    int unsigned accesses;
    int unsigned mismatches;
    int unsigned region_hits[9];

    function new();
      itcm_on    = 1'b0;
      itcm_span  = '0;
      dtcm_on    = 1'b0;
      dtcm_start = '0;
      dtcm_span  = '0;
      accesses   = 0;
      mismatches = 0;
      foreach (region_hits[i]) region_hits[i] = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_ITCM_ON:    itcm_on    = data[0];
        CFG_ITCM_SPAN:  itcm_span  = data;
        CFG_DTCM_ON:    dtcm_on    = data[0];
        CFG_DTCM_START: dtcm_start = data;
        CFG_DTCM_SPAN:  dtcm_span  = data;
        default: ;
      endcase
    endfunction

    function logic under_itcm_span(logic first, logic [31:0] a);
      return first && itcm_on && (itcm_span != 32'd0) && (a < MAIN_BASE) && (a < itcm_span);
    endfunction

    // Walk the map in priority order; an access that overruns its store drops to the next rule.
    function out_item_t decode_access(in_item_t it);
      logic        first;
      logic        hit;
      logic [31:0] a;
      logic [31:0] o;
      logic [32:0] len;
      out_item_t   r;
      first    = (it.cpu_sel == CPU_MAIN);
      a        = it.address;
      len      = 33'(it.width_bytes);
      hit      = 1'b0;
      r.region = RG_NONE;
      r.offset = '0;
      if (under_itcm_span(first, a)) begin
        o = a & ITCM_MASK;
        if (33'(o) + len <= 33'(ITCM_BYTES)) begin
          r.region = RG_ITCM; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && first && dtcm_on && (dtcm_span != 32'd0) && (a >= dtcm_start) &&
          (a - dtcm_start < dtcm_span)) begin
        o = a - dtcm_start;
        if (33'(o) + len <= 33'(DTCM_BYTES)) begin
          r.region = RG_DTCM; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && (a >= MAIN_BASE) && (a < SWRAM_BASE)) begin
        o = a & MAIN_MASK;
        if (33'(o) + len <= 33'(MAIN_MASK) + 33'd1) begin
          r.region = RG_MAIN; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && (a >= SWRAM_BASE) && (a < WRAM7_BASE)) begin
        o = a & SWRAM_MASK;
        if (33'(o) + len <= 33'(SWRAM_MASK) + 33'd1) begin
          r.region = RG_SWRAM; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && (a >= WRAM7_BASE) && (a < IO_BASE)) begin
        o = a & WRAM7_MASK;
        if (33'(o) + len <= 33'(WRAM7_MASK) + 33'd1) begin
          r.region = RG_WRAM7; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && first && (a >= BIOS9_BASE)) begin
        o = a & BIOS9_MASK;
        if (33'(o) + len <= 33'(BIOS9_MASK) + 33'd1) begin
          r.region = RG_BIOS9; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit && !first && (a < BIOS7_TOP)) begin
        o = a & BIOS7_MASK;
        if (33'(o) + len <= 33'(BIOS7_TOP)) begin
          r.region = RG_BIOS7; r.offset = o[21:0]; hit = 1'b1;
        end
      end
      if (!hit) begin
        r.offset = '0;
        r.region = ((a >= IO_BASE) && (a < IO_TOP)) ? RG_IO : RG_NONE;
      end
      r.exec_ram = under_itcm_span(first, a) || ((a >= MAIN_BASE) && (a < IO_BASE));
      return r;
    endfunction

    function void note_access(in_item_t it);
      pending.push_back(decode_access(it));
      accesses++;
    endfunction

    task flag(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        flag($sformatf("result with nothing outstanding (region %0d offset 0x%06h)",
                       got.region, got.offset));
        return;
      end
      want = pending.pop_front();
      if (got.region !== want.region)
        flag($sformatf("region %0d, expected %0d", got.region, want.region));
      if (got.offset !== want.offset)
        flag($sformatf("offset 0x%06h, expected 0x%06h", got.offset, want.offset));
      if (got.exec_ram !== want.exec_ram)
        flag($sformatf("exec_ram %0b, expected %0b", got.exec_ram, want.exec_ram));
      region_hits[want.region]++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  decode_scoreboard sb = new();
  int unsigned src_idle_max  = 0;
  int unsigned sink_idle_max = 0;
  bit          hold_request  = 1'b0;
  int unsigned cfg_writes    = 0;
  int unsigned holds_done    = 0;

  dual_cpu_memory_map_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t access(logic cpu, logic [31:0] addr, logic [2:0] w);
    in_item_t it;
    it.cpu_sel     = cpu;
    it.address     = addr;
    it.width_bytes = w;
    return it;
  endfunction

  // Bias addresses towards region edges, mirror tops and the TCM windows.
  function automatic in_item_t random_access();
    in_item_t    it;
    logic [31:0] a;
    case ($urandom_range(0, 9))
      0, 1: a = $urandom;
      2: begin
        case ($urandom_range(0, 7))
          0: a = 32'h0;
          1: a = MAIN_BASE;
          2: a = SWRAM_BASE;
          3: a = WRAM7_BASE;
          4: a = IO_BASE;
          5: a = IO_TOP;
          6: a = BIOS9_BASE;
          default: a = BIOS7_TOP;
        endcase
        a = a + 32'($urandom_range(0, 15)) - 32'd8;
      end
      3: begin
        a = MAIN_BASE | ($urandom & 32'h01FF_FFFF);
        case ($urandom_range(0, 3))
          0: ;
          1: a = a | 32'h0000_7FF8;
          2: a = a | 32'h0000_FFF8;
          default: a = a | 32'h003F_FFF8;
        endcase
      end
      4: a = BIOS9_BASE | ($urandom & 32'h0000_FFFF) |
             (($urandom_range(0, 1) != 0) ? 32'h0000_0FF8 : 32'h0);
      5: a = ($urandom & (($urandom_range(0, 1) != 0) ? 32'h01FF_FFFF : 32'h0000_FFFF)) |
             (($urandom_range(0, 1) != 0) ? 32'h0000_3FF8 : 32'h0000_7FF8);
      6: a = sb.itcm_span + 32'($urandom_range(0, 15)) - 32'd8;
      7: a = sb.dtcm_start + 32'($urandom_range(0, 31)) - 32'd8;
      8: a = sb.dtcm_start + (sb.dtcm_span & 32'h0000_7FFF) + 32'($urandom_range(0, 15)) - 32'd8;
      default: a = sb.dtcm_start + sb.dtcm_span + 32'($urandom_range(0, 15)) - 32'd8;
    endcase
    it.cpu_sel     = 1'($urandom_range(0, 1));
    it.address     = a;
    it.width_bytes = ($urandom_range(0, 9) < 7) ? 3'(1 << $urandom_range(0, 2))
                                                : 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic map_setting_t plan_for(int ph);
    map_setting_t s;
    case (ph)
      0: s = '{32'h1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF};
      1: s = '{32'hFFFF_FFFF, 32'h0000_8001, 32'h1, 32'hFFFF_C000, 32'h0000_4000};
      2: s = '{32'hFFFF_FFFE, 32'h0100_0000, 32'hAAAA_AAAA, MAIN_BASE, 32'h0000_8000};
      3: s = '{32'h1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0};
      5: s = '{32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      default: begin
        s.itcm_on    = $urandom;
        s.itcm_span  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'h0200_4000) : $urandom;
        s.dtcm_on    = $urandom;
        s.dtcm_start = ($urandom_range(0, 1) != 0) ? ($urandom & 32'h03FF_F000) : $urandom;
        s.dtcm_span  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'h8000) : $urandom;
      end
    endcase
    return s;
  endfunction

  task automatic send_access(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(it);
  endtask

  task automatic stop_sending();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic apply_map(map_setting_t s);
    write_reg(CFG_ITCM_ON, s.itcm_on);
    write_reg(CFG_ITCM_SPAN, s.itcm_span);
    write_reg(CFG_DTCM_ON, s.dtcm_on);
    write_reg(CFG_DTCM_START, s.dtcm_start);
    write_reg(CFG_DTCM_SPAN, s.dtcm_span);
    // Unassigned index: must leave every register alone.
    write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
  endtask

  // Sink: random ready gaps, one long hold on request to back the decoder up.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
        holds_done++;
      end else begin
        gap = $urandom_range(0, sink_idle_max);
      end
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL dual_cpu_memory_map_decoder_top");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ITCM_ON;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // TCMs off as after reset: plain map, mirror ends, straddles, odd widths.
    src_idle_max  = 3;
    sink_idle_max = 3;
    send_access(access(CPU_MAIN, 32'h0000_0000, 3'd1));
    send_access(access(CPU_SUB,  32'h0000_0000, 3'd4));
    send_access(access(CPU_SUB,  32'h0000_3FFC, 3'd4));
    send_access(access(CPU_SUB,  32'h0000_3FFD, 3'd4));
    send_access(access(CPU_MAIN, 32'h01FF_FFFF, 3'd1));
    send_access(access(CPU_MAIN, MAIN_BASE, 3'd4));
    send_access(access(CPU_SUB,  32'h02FF_FFFE, 3'd2));
    send_access(access(CPU_MAIN, 32'h023F_FFFD, 3'd4));
    send_access(access(CPU_MAIN, 32'h0300_7FFF, 3'd2));
    send_access(access(CPU_SUB,  32'h037F_FFF8, 3'd4));
    send_access(access(CPU_MAIN, 32'h03FF_FFFC, 3'd4));
    send_access(access(CPU_SUB,  32'h0380_FFFF, 3'd7));
    send_access(access(CPU_MAIN, IO_BASE, 3'd0));
    send_access(access(CPU_SUB,  32'h04FF_FFFF, 3'd4));
    send_access(access(CPU_MAIN, IO_TOP, 3'd2));
    send_access(access(CPU_MAIN, 32'hFFFF_0FFC, 3'd4));
    send_access(access(CPU_MAIN, 32'hFFFF_FFFF, 3'd2));
    send_access(access(CPU_SUB,  BIOS9_BASE, 3'd1));
    stop_sending();
    wait_drained();

    // Small ITCM span and a DTCM window laid over the top of main RAM.
    apply_map('{32'h1, 32'h0001_0000, 32'h1, 32'h027F_C000, 32'h0000_4000});
    send_access(access(CPU_MAIN, 32'h0000_0000, 3'd4));
    send_access(access(CPU_MAIN, 32'h0000_FFFE, 3'd4));
    send_access(access(CPU_SUB,  32'h0000_0010, 3'd2));
    send_access(access(CPU_MAIN, 32'h027F_C000, 3'd4));
    send_access(access(CPU_MAIN, 32'h027F_FFFD, 3'd4));
    send_access(access(CPU_SUB,  32'h027F_C000, 3'd4));
    send_access(access(CPU_MAIN, 32'h0001_0000, 3'd1));
    stop_sending();
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_map(plan_for(ph));
      src_idle_max  = (ph % 2 == 0) ? 9 : 0;
      sink_idle_max = (ph % 3 == 0) ? 0 : 9;
      if (ph == 1) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_access(random_access());
      stop_sending();
      wait_drained();
    end

    $display("Decoded %0d accesses from both CPUs over %0d register writes, %0d long sink holds.",
             sb.accesses, cfg_writes, holds_done);
    $display("By region: itcm %0d dtcm %0d main %0d swram %0d wram7 %0d bios9 %0d bios7 %0d io %0d unmapped %0d",
             sb.region_hits[RG_ITCM], sb.region_hits[RG_DTCM], sb.region_hits[RG_MAIN],
             sb.region_hits[RG_SWRAM], sb.region_hits[RG_WRAM7], sb.region_hits[RG_BIOS9],
             sb.region_hits[RG_BIOS7], sb.region_hits[RG_IO], sb.region_hits[RG_NONE]);
    if (sb.mismatches == 0)
      $display("PASS dual_cpu_memory_map_decoder_top");
    else
      $display("FAIL dual_cpu_memory_map_decoder_top");
    $finish;
  end

endmodule
